@@ rtl/rm2q_pkg.sv @@
// Shared types and constants for the rotation matrix to quaternion pipeline.
// No dependencies.
package rm2q_pkg;

    typedef enum logic [1:0] {
        CASE_TRACE = 2'd0,
        CASE_X     = 2'd1,
        CASE_Y     = 2'd2,
        CASE_Z     = 2'd3
    } t_case;

    typedef struct packed {
        t_case cs;
        logic  degen;
    } t_ctl;

    // magnitudes are scaled below 2^MAG_LIMIT_LOG2 before squaring
    localparam int MAG_LIMIT_LOG2 = 30;

endpackage

@@ rtl/rotation_matrix_to_quaternion.sv @@
// Rotation matrix (Q2.14) to unit quaternion, Shepperd case selection.
// Throughput: one matrix per cycle; busy is always low.
// Pipeline from start to o_valid: front end, RW = MW + 1 root stages (one bit per
//   stage), the divider and an output register.
// Reset clears only the valid pipeline; results cannot be stalled.
module rotation_matrix_to_quaternion #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [DATA_WIDTH-1:0] i_m00,
    input  logic [DATA_WIDTH-1:0] i_m01,
    input  logic [DATA_WIDTH-1:0] i_m02,
    input  logic [DATA_WIDTH-1:0] i_m10,
    input  logic [DATA_WIDTH-1:0] i_m11,
    input  logic [DATA_WIDTH-1:0] i_m12,
    input  logic [DATA_WIDTH-1:0] i_m20,
    input  logic [DATA_WIDTH-1:0] i_m21,
    input  logic [DATA_WIDTH-1:0] i_m22,
    output logic                  o_valid,
    output logic [DATA_WIDTH-1:0] o_qx,
    output logic [DATA_WIDTH-1:0] o_qy,
    output logic [DATA_WIDTH-1:0] o_qz,
    output logic [DATA_WIDTH-1:0] o_qw,
    output logic [1:0]            o_case_used,
    output logic                  o_degenerate
);
    import rm2q_pkg::*;

    localparam int VW     = DATA_WIDTH + 3;
    localparam int MW     = (VW > MAG_LIMIT_LOG2) ? MAG_LIMIT_LOG2 : VW;
    localparam int SW     = 2 * MW + 2;
    localparam int RW     = MW + 1;
    localparam int CW     = $bits(t_ctl);
    localparam int SIDE1  = CW + 4 + 4 * MW;
    localparam int SIDE2  = CW + 4;
    localparam logic [DATA_WIDTH-1:0] ONE_D = DATA_WIDTH'(64'd1 << FRAC_BITS);

    logic               f_vld;
    t_ctl               f_ctl;
    logic [3:0]         f_neg;
    logic [3:0][MW-1:0] f_mag;
    logic [SW-1:0]      f_sum;

    logic               s_vld;
    logic [RW-1:0]      s_root;
    logic [SIDE1-1:0]   s_side;
    t_ctl               s_ctl;
    t_ctl               s_ctl_upd;
    logic [3:0]         s_neg;
    logic [3:0][MW-1:0] s_mag;

    logic                       d_vld;
    logic [3:0][FRAC_BITS:0]    d_q;
    logic [SIDE2-1:0]           d_side;
    t_ctl                       d_ctl;
    logic [3:0]                 d_neg;

    logic [3:0][DATA_WIDTH-1:0] n_q;
    logic                       r_valid;
    logic [3:0][DATA_WIDTH-1:0] r_q;
    t_ctl                       r_ctl;

    assign busy = 1'b0;

    rm2q_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .VW         (VW),
        .MW         (MW),
        .SW         (SW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start),
        .i_m     ({i_m22, i_m21, i_m20, i_m12, i_m11, i_m10, i_m02, i_m01, i_m00}),
        .o_vld   (f_vld),
        .o_ctl   (f_ctl),
        .o_neg   (f_neg),
        .o_mag   (f_mag),
        .o_sum   (f_sum)
    );

    rm2q_isqrt #(
        .SW     (SW),
        .RW     (RW),
        .SIDE_W (SIDE1)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (f_vld),
        .i_rad   (f_sum),
        .i_side  ({f_ctl, f_neg, f_mag}),
        .o_vld   (s_vld),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    assign {s_ctl, s_neg, s_mag} = s_side;

    // zero norm folds into the degenerate flag
    always_comb begin
        s_ctl_upd       = s_ctl;
        s_ctl_upd.degen = s_ctl.degen | (s_root == '0);
    end

    rm2q_div #(
        .MW        (MW),
        .RW        (RW),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE2)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s_vld),
        .i_den   (s_root),
        .i_mag   (s_mag),
        .i_side  ({s_ctl_upd, s_neg}),
        .o_vld   (d_vld),
        .o_q     (d_q),
        .o_side  (d_side)
    );

    assign {d_ctl, d_neg} = d_side;

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            n_q[l] = d_neg[l] ? DATA_WIDTH'(-DATA_WIDTH'(d_q[l])) : DATA_WIDTH'(d_q[l]);
        end
        if (d_ctl.degen) begin
            n_q[0] = '0;
            n_q[1] = '0;
            n_q[2] = '0;
            n_q[3] = ONE_D;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_ctl <= d_ctl;
    end

    assign o_valid      = r_valid;
    assign o_qx         = r_q[0];
    assign o_qy         = r_q[1];
    assign o_qz         = r_q[2];
    assign o_qw         = r_q[3];
    assign o_case_used  = r_ctl.cs;
    assign o_degenerate = r_ctl.degen;

endmodule

@@ rtl/rm2q_front.sv @@
// Front end: case selection, component vector, magnitude scaling, sum of squares.
// Depends on rm2q_pkg.
module rm2q_front #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14,
    parameter int VW         = 19,
    parameter int MW         = 19,
    parameter int SW         = 40
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [8:0][DATA_WIDTH-1:0]    i_m,
    output logic                          o_vld,
    output rm2q_pkg::t_ctl                o_ctl,
    output logic [3:0]                    o_neg,
    output logic [3:0][MW-1:0]            o_mag,
    output logic [SW-1:0]                 o_sum
);
    import rm2q_pkg::*;

    localparam logic signed [VW-1:0] ONE_V = VW'(64'sd1 << FRAC_BITS);
    localparam int KMAX = (VW > MAG_LIMIT_LOG2) ? VW - MAG_LIMIT_LOG2 : 0;
    localparam int KW   = $clog2(KMAX + 2);

    // stage 1: input capture
    logic                          r1_vld;
    logic [8:0][DATA_WIDTH-1:0]    r1_m;

    // stage 2: case and vector
    logic signed [VW-1:0]  e [9];
    logic signed [VW-1:0]  trace;
    logic signed [VW-1:0]  t;
    logic signed [VW-1:0]  n_v [4];
    t_ctl                  n_ctl2;
    logic                  r2_vld;
    logic signed [VW-1:0]  r2_v [4];
    t_ctl                  r2_ctl;

    // stage 3: magnitudes and max
    logic [3:0][VW-1:0]    n_mag3;
    logic [3:0]            n_neg3;
    logic [VW-1:0]         big01, big23, n_big;
    logic                  r3_vld;
    logic [3:0][VW-1:0]    r3_mag;
    logic [3:0]            r3_neg;
    logic [VW-1:0]         r3_big;
    t_ctl                  r3_ctl;

    // stage 4: scale
    logic [KW-1:0]         k;
    logic [3:0][MW-1:0]    n_mag4;
    logic                  r4_vld;
    logic [3:0][MW-1:0]    r4_mag;
    logic [3:0]            r4_neg;
    t_ctl                  r4_ctl;

    // stage 5: squares
    logic                  r5_vld;
    logic [3:0][2*MW-1:0]  r5_sq;
    logic [3:0][MW-1:0]    r5_mag;
    logic [3:0]            r5_neg;
    t_ctl                  r5_ctl;

    // stage 6: sum
    logic                  r6_vld;
    logic [SW-1:0]         r6_sum;
    logic [3:0][MW-1:0]    r6_mag;
    logic [3:0]            r6_neg;
    t_ctl                  r6_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_m <= i_m;
    end

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            e[i] = {{(VW-DATA_WIDTH){r1_m[i][DATA_WIDTH-1]}}, r1_m[i]};
        end
        trace = e[0] + e[4] + e[8];
        if (trace > 0) begin
            n_ctl2.cs = CASE_TRACE;
            t      = ONE_V + trace;
            n_v[0] = e[7] - e[5];
            n_v[1] = e[2] - e[6];
            n_v[2] = e[3] - e[1];
            n_v[3] = t;
        end else if (e[0] > e[4] && e[0] > e[8]) begin
            n_ctl2.cs = CASE_X;
            t      = ONE_V + e[0] - e[4] - e[8];
            n_v[0] = t;
            n_v[1] = e[1] + e[3];
            n_v[2] = e[2] + e[6];
            n_v[3] = e[7] - e[5];
        end else if (e[4] > e[8]) begin
            n_ctl2.cs = CASE_Y;
            t      = ONE_V - e[0] + e[4] - e[8];
            n_v[0] = e[1] + e[3];
            n_v[1] = t;
            n_v[2] = e[5] + e[7];
            n_v[3] = e[2] - e[6];
        end else begin
            n_ctl2.cs = CASE_Z;
            t      = ONE_V - e[0] - e[4] + e[8];
            n_v[0] = e[2] + e[6];
            n_v[1] = e[5] + e[7];
            n_v[2] = t;
            n_v[3] = e[3] - e[1];
        end
        n_ctl2.degen = (t <= 0);
    end

    always_ff @(posedge i_clk) begin
        r2_v   <= n_v;
        r2_ctl <= n_ctl2;
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_neg3[i] = r2_v[i][VW-1];
            n_mag3[i] = n_neg3[i] ? VW'(-r2_v[i]) : VW'(r2_v[i]);
        end
        big01 = (n_mag3[1] > n_mag3[0]) ? n_mag3[1] : n_mag3[0];
        big23 = (n_mag3[3] > n_mag3[2]) ? n_mag3[3] : n_mag3[2];
        n_big = (big23 > big01) ? big23 : big01;
    end

    always_ff @(posedge i_clk) begin
        r3_mag <= n_mag3;
        r3_neg <= n_neg3;
        r3_big <= n_big;
        r3_ctl <= r2_ctl;
    end

    // smallest right shift that brings the largest magnitude under the limit
    always_comb begin
        k = KW'(KMAX);
        for (int j = KMAX; j >= 0; j--) begin
            if (((r3_big >> j) >> MAG_LIMIT_LOG2) == '0) begin
                k = KW'(j);
            end
        end
        for (int i = 0; i < 4; i++) begin
            n_mag4[i] = MW'(r3_mag[i] >> k);
        end
    end

    always_ff @(posedge i_clk) begin
        r4_mag <= n_mag4;
        r4_neg <= r3_neg;
        r4_ctl <= r3_ctl;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r5_sq[i] <= (2*MW)'(r4_mag[i]) * (2*MW)'(r4_mag[i]);
        end
        r5_mag <= r4_mag;
        r5_neg <= r4_neg;
        r5_ctl <= r4_ctl;
    end

    always_ff @(posedge i_clk) begin
        r6_sum <= SW'(r5_sq[0]) + SW'(r5_sq[1]) + SW'(r5_sq[2]) + SW'(r5_sq[3]);
        r6_mag <= r5_mag;
        r6_neg <= r5_neg;
        r6_ctl <= r5_ctl;
    end

    assign o_vld = r6_vld;
    assign o_ctl = r6_ctl;
    assign o_neg = r6_neg;
    assign o_mag = r6_mag;
    assign o_sum = r6_sum;

endmodule

@@ rtl/rm2q_isqrt.sv @@
// Pipelined integer square root, one root bit per stage, with sideband.
// Depends on rm2q_pkg.
module rm2q_isqrt #(
    parameter int SW     = 40,
    parameter int RW     = 20,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [SW-1:0]     i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [RW-1:0]     o_root,
    output logic [SIDE_W-1:0] o_side
);
    import rm2q_pkg::*;

    // remainder = radicand - root^2 as bits are settled MSB first
    logic [SW:0]       s_rem  [RW];
    logic [RW-1:0]     s_root [RW];
    logic [SIDE_W-1:0] s_side [RW];
    logic              s_vld  [RW];
    logic [SW:0]       r_rem  [RW];
    logic [RW-1:0]     r_root [RW];
    logic [SIDE_W-1:0] r_side [RW];
    logic              r_vld  [RW];

    assign s_rem[0]  = (SW+1)'(i_rad);
    assign s_root[0] = '0;
    assign s_side[0] = i_side;
    assign s_vld[0]  = i_vld;

    for (genvar j = 0; j < RW; j++) begin : g_stage
        localparam int B = RW - 1 - j;
        logic [SW:0]   trial;
        logic [SW:0]   n_rem;
        logic [RW-1:0] n_root;

        if (j > 0) begin : g_link
            assign s_rem[j]  = r_rem[j-1];
            assign s_root[j] = r_root[j-1];
            assign s_side[j] = r_side[j-1];
            assign s_vld[j]  = r_vld[j-1];
        end

        always_comb begin
            trial = ((SW+1)'(s_root[j]) << (B + 1)) + ((SW+1)'(1) << (2 * B));
            if (s_rem[j] >= trial) begin
                n_rem  = s_rem[j] - trial;
                n_root = s_root[j] | (RW'(1) << B);
            end else begin
                n_rem  = s_rem[j];
                n_root = s_root[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else begin
                r_vld[j] <= s_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[j]  <= n_rem;
            r_root[j] <= n_root;
            r_side[j] <= s_side[j];
        end
    end

    assign o_vld  = r_vld[RW-1];
    assign o_root = r_root[RW-1];
    assign o_side = r_side[RW-1];

endmodule

@@ rtl/rm2q_div.sv @@
// Four-lane pipelined rounding divider: q = (2*mag*ONE + n) / (2*n), one bit per stage.
// Depends on rm2q_pkg.
module rm2q_div #(
    parameter int MW        = 19,
    parameter int RW        = 20,
    parameter int FRAC_BITS = 14,
    parameter int SIDE_W    = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [RW-1:0]                 i_den,
    input  logic [3:0][MW-1:0]            i_mag,
    input  logic [SIDE_W-1:0]             i_side,
    output logic                          o_vld,
    output logic [3:0][FRAC_BITS:0]       o_q,
    output logic [SIDE_W-1:0]             o_side
);
    import rm2q_pkg::*;

    localparam int QW = FRAC_BITS + 1;
    localparam int NW = RW + FRAC_BITS + 2;

    logic [3:0][NW-1:0] s_rem  [QW];
    logic [3:0][QW-1:0] s_q    [QW];
    logic [RW:0]        s_den  [QW];
    logic [SIDE_W-1:0]  s_side [QW];
    logic               s_vld  [QW];
    logic [3:0][NW-1:0] r_rem  [QW];
    logic [3:0][QW-1:0] r_q    [QW];
    logic [RW:0]        r_den  [QW];
    logic [SIDE_W-1:0]  r_side [QW];
    logic               r_vld  [QW];

    for (genvar l = 0; l < 4; l++) begin : g_num
        assign s_rem[0][l] = (NW'(i_mag[l]) << (FRAC_BITS + 1)) + NW'(i_den);
    end
    assign s_q[0]    = '0;
    assign s_den[0]  = {i_den, 1'b0};
    assign s_side[0] = i_side;
    assign s_vld[0]  = i_vld;

    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int B = QW - 1 - j;
        logic [NW-1:0]      dsh;
        logic [3:0][NW-1:0] n_rem;
        logic [3:0][QW-1:0] n_q;

        if (j > 0) begin : g_link
            assign s_rem[j]  = r_rem[j-1];
            assign s_q[j]    = r_q[j-1];
            assign s_den[j]  = r_den[j-1];
            assign s_side[j] = r_side[j-1];
            assign s_vld[j]  = r_vld[j-1];
        end

        always_comb begin
            dsh = NW'(s_den[j]) << B;
            for (int l = 0; l < 4; l++) begin
                if (s_rem[j][l] >= dsh) begin
                    n_rem[l] = s_rem[j][l] - dsh;
                    n_q[l]   = s_q[j][l] | (QW'(1) << B);
                end else begin
                    n_rem[l] = s_rem[j][l];
                    n_q[l]   = s_q[j][l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else begin
                r_vld[j] <= s_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[j]  <= n_rem;
            r_q[j]    <= n_q;
            r_den[j]  <= s_den[j];
            r_side[j] <= s_side[j];
        end
    end

    assign o_vld  = r_vld[QW-1];
    assign o_q    = r_q[QW-1];
    assign o_side = r_side[QW-1];

endmodule
